[design/sparse_local_mean_subtract_3d_core_assert.svh]
// Assertion macros for the checker of the local mean subtraction core.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef SPARSE_LOCAL_MEAN_SUBTRACT_3D_CORE_ASSERT_SVH
`define SPARSE_LOCAL_MEAN_SUBTRACT_3D_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLMS3D_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLMS3D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/slms3d_pkg.sv]
// Shared constants for the sparse local mean subtraction core.
// No dependencies; used by the core, its checker and the testbench.
`timescale 1ns / 1ps

package slms3d_pkg;

	// Default sizes of the volume and of the neighbour pattern.
	localparam int MAX_WIDTH_DEF    = 128;
	localparam int MAX_HEIGHT_DEF   = 128;
	localparam int MAX_LAYERS_DEF   = 32;
	localparam int STEP_SPACING_DEF = 5;
	localparam int RING_COUNT_DEF   = 3;

	// Port field widths.
	localparam int VALUE_W  = 8;
	localparam int POS_X_W  = 7;
	localparam int POS_Y_W  = 7;
	localparam int POS_Z_W  = 5;
	localparam int COUNT_W  = 5;
	localparam int DIM_XY_W = 8;
	localparam int DIM_Z_W  = 6;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LAYERS = 2'd2;

	localparam logic [DIM_XY_W-1:0] WIDTH_RST  = 8'd128;
	localparam logic [DIM_XY_W-1:0] HEIGHT_RST = 8'd128;
	localparam logic [DIM_Z_W-1:0]  LAYERS_RST = 6'd32;

	// Command codes.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Neighbour directions, visited in this order within each ring.
	localparam int DIR_W = 3;
	localparam logic [DIR_W-1:0] DIR_XM = 3'd0;
	localparam logic [DIR_W-1:0] DIR_XP = 3'd1;
	localparam logic [DIR_W-1:0] DIR_YM = 3'd2;
	localparam logic [DIR_W-1:0] DIR_YP = 3'd3;
	localparam logic [DIR_W-1:0] DIR_ZM = 3'd4;
	localparam logic [DIR_W-1:0] DIR_ZP = 3'd5;

endpackage

[design/sparse_local_mean_subtract_3d_core.sv]
// Top level of the sparse local mean subtraction core over a 3D byte volume.
// Depends on slms3d_pkg, slms3d_ram and slms3d_div.
//
//   channel   handshake            payload
//   input     start / busy         cmd, voxel_value, pos_x, pos_y, pos_z
//   result    result_valid strobe  result_value, neighbour_count
//   config    cfg_we               cfg_index, cfg_wdata
//
// A write, or a query outside the active volume, is taken without raising busy.
// A query inside the volume scans the centre and its rings, then divides:
// one voxel read per cycle through the single RAM read port, then one quotient bit per cycle.
// A query with no neighbours skips the division.
// Reset clears control and configuration only; the voxel store holds no reset value.
// The result is a one-cycle strobe that the receiver cannot stall.
`timescale 1ns / 1ps

module sparse_local_mean_subtract_3d_core #(
	parameter int MAX_WIDTH    = slms3d_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT   = slms3d_pkg::MAX_HEIGHT_DEF,
	parameter int MAX_LAYERS   = slms3d_pkg::MAX_LAYERS_DEF,
	parameter int STEP_SPACING = slms3d_pkg::STEP_SPACING_DEF,
	parameter int RING_COUNT   = slms3d_pkg::RING_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                cmd,
	input  logic [slms3d_pkg::VALUE_W-1:0]      voxel_value,
	input  logic [slms3d_pkg::POS_X_W-1:0]      pos_x,
	input  logic [slms3d_pkg::POS_Y_W-1:0]      pos_y,
	input  logic [slms3d_pkg::POS_Z_W-1:0]      pos_z,
	input  logic                                cfg_we,
	input  logic [slms3d_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [slms3d_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output logic                                result_valid,
	output logic [slms3d_pkg::VALUE_W-1:0]      result_value,
	output logic [slms3d_pkg::COUNT_W-1:0]      neighbour_count
);

	localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_LAYERS;
	localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int EW          = $clog2(MAX_WIDTH + MAX_HEIGHT + MAX_LAYERS + 256
		+ STEP_SPACING * RING_COUNT);
	localparam int RW          = $clog2(RING_COUNT + 1);
	localparam int MAX_CNT     = 6 * RING_COUNT;
	localparam int CNT_W       = $clog2(MAX_CNT + 1);
	localparam int SUM_W       = $clog2(255 * MAX_CNT + 1);
	localparam int NUM_W       = SUM_W + 1;
	localparam int VAL_W       = slms3d_pkg::VALUE_W;
	localparam int OUT_CNT_W   = slms3d_pkg::COUNT_W;
	localparam int DIR_W       = slms3d_pkg::DIR_W;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DIV   = 2'd3;

	function automatic logic [AW-1:0] voxel_addr(input logic [EW-1:0] xc,
		input logic [EW-1:0] yc, input logic [EW-1:0] zc);
		logic [31:0] a;
		a = (32'(zc) * 32'(MAX_HEIGHT) + 32'(yc)) * 32'(MAX_WIDTH) + 32'(xc);
		return a[AW-1:0];
	endfunction

	// Configuration registers.
	logic [slms3d_pkg::DIM_XY_W-1:0] vol_width_q;
	logic [slms3d_pkg::DIM_XY_W-1:0] vol_height_q;
	logic [slms3d_pkg::DIM_Z_W-1:0]  vol_layers_q;

	logic [EW-1:0] dim_w;
	logic [EW-1:0] dim_h;
	logic [EW-1:0] dim_l;

	logic [1:0]       state_q;
	logic [EW-1:0]    x_q;
	logic [EW-1:0]    y_q;
	logic [EW-1:0]    z_q;
	logic             centre_phase_q;
	logic [DIR_W-1:0] dir_q;
	logic [RW-1:0]    ring_q;
	logic [EW-1:0]    off_q;

	logic             vld_s1;
	logic             ctr_s1;
	logic [AW-1:0]    addr_s1;
	logic             vld_s2;
	logic             ctr_s2;

	logic [VAL_W-1:0]     centre_q;
	logic [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 res_valid_q;
	logic [VAL_W-1:0]     res_value_q;
	logic [OUT_CNT_W-1:0] res_cnt_q;

	logic [EW-1:0] in_x;
	logic [EW-1:0] in_y;
	logic [EW-1:0] in_z;
	logic          inside_in;
	logic          accept;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [VAL_W-1:0] ram_rdata;

	logic [EW-1:0] cx;
	logic [EW-1:0] cy;
	logic [EW-1:0] cz;
	logic          cvalid;
	logic          drained;
	logic          div_start;
	logic          div_done;
	logic [NUM_W-1:0] div_num;
	logic [NUM_W-1:0] div_quot;
	logic [NUM_W-1:0] centre_ext;

	assign dim_w = (EW'(vol_width_q) > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(vol_width_q);
	assign dim_h = (EW'(vol_height_q) > EW'(MAX_HEIGHT)) ? EW'(MAX_HEIGHT)
		: EW'(vol_height_q);
	assign dim_l = (EW'(vol_layers_q) > EW'(MAX_LAYERS)) ? EW'(MAX_LAYERS)
		: EW'(vol_layers_q);

	assign in_x      = EW'(pos_x);
	assign in_y      = EW'(pos_y);
	assign in_z      = EW'(pos_z);
	assign inside_in = (in_x < dim_w) && (in_y < dim_h) && (in_z < dim_l);
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign ram_we    = accept && (cmd == slms3d_pkg::CMD_WRITE) && inside_in;
	assign ram_waddr = voxel_addr(in_x, in_y, in_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_width_q  <= slms3d_pkg::WIDTH_RST;
			vol_height_q <= slms3d_pkg::HEIGHT_RST;
			vol_layers_q <= slms3d_pkg::LAYERS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				slms3d_pkg::REG_WIDTH:  vol_width_q  <= cfg_wdata;
				slms3d_pkg::REG_HEIGHT: vol_height_q <= cfg_wdata;
				slms3d_pkg::REG_LAYERS: vol_layers_q <= cfg_wdata[slms3d_pkg::DIM_Z_W-1:0];
				default: ;
			endcase
		end
	end

	// Candidate voxel for this scan cycle: the centre first, then each ring in turn.
	always_comb begin
		cx     = x_q;
		cy     = y_q;
		cz     = z_q;
		cvalid = 1'b0;
		if (centre_phase_q) begin
			cvalid = 1'b1;
		end else begin
			unique case (dir_q)
				slms3d_pkg::DIR_XM: begin
					cvalid = (x_q > off_q);
					cx     = x_q - off_q;
				end
				slms3d_pkg::DIR_XP: begin
					cvalid = ((x_q + off_q) < dim_w);
					cx     = x_q + off_q;
				end
				slms3d_pkg::DIR_YM: begin
					cvalid = (y_q > off_q);
					cy     = y_q - off_q;
				end
				slms3d_pkg::DIR_YP: begin
					cvalid = ((y_q + off_q) < dim_h);
					cy     = y_q + off_q;
				end
				slms3d_pkg::DIR_ZM: begin
					cvalid = (z_q > off_q);
					cz     = z_q - off_q;
				end
				slms3d_pkg::DIR_ZP: begin
					cvalid = ((z_q + off_q) < dim_l);
					cz     = z_q + off_q;
				end
				default: cvalid = 1'b0;
			endcase
		end
	end

	assign drained    = !vld_s1 && !vld_s2;
	assign div_start  = (state_q == ST_DRAIN) && drained && (cnt_q != '0);
	assign div_num    = NUM_W'(sum_q) + NUM_W'(cnt_q) - NUM_W'(1);
	assign centre_ext = NUM_W'(centre_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			centre_phase_q <= 1'b0;
			dir_q          <= slms3d_pkg::DIR_XM;
			ring_q         <= '0;
			vld_s1         <= 1'b0;
			ctr_s1         <= 1'b0;
			vld_s2         <= 1'b0;
			ctr_s2         <= 1'b0;
			cnt_q          <= '0;
			res_valid_q    <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			vld_s1      <= (state_q == ST_SCAN) && cvalid;
			ctr_s1      <= centre_phase_q;
			vld_s2      <= vld_s1;
			ctr_s2      <= ctr_s1;
			if (vld_s2 && !ctr_s2) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (cmd == slms3d_pkg::CMD_QUERY)) begin
						cnt_q <= '0;
						if (inside_in) begin
							state_q        <= ST_SCAN;
							centre_phase_q <= 1'b1;
						end else begin
							res_valid_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (centre_phase_q) begin
						centre_phase_q <= 1'b0;
						dir_q          <= slms3d_pkg::DIR_XM;
						ring_q         <= RW'(1);
					end else if (dir_q == slms3d_pkg::DIR_ZP) begin
						dir_q <= slms3d_pkg::DIR_XM;
						if (ring_q == RW'(RING_COUNT)) begin
							state_q <= ST_DRAIN;
						end else begin
							ring_q <= ring_q + RW'(1);
						end
					end else begin
						dir_q <= dir_q + DIR_W'(1);
					end
				end
				ST_DRAIN: begin
					if (drained) begin
						if (cnt_q == '0) begin
							res_valid_q <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= voxel_addr(cx, cy, cz);
		if (state_q == ST_SCAN) begin
			if (centre_phase_q) begin
				off_q <= EW'(STEP_SPACING);
			end else if (dir_q == slms3d_pkg::DIR_ZP) begin
				off_q <= off_q + EW'(STEP_SPACING);
			end
		end
		if (accept) begin
			x_q   <= in_x;
			y_q   <= in_y;
			z_q   <= in_z;
			sum_q <= '0;
		end else if (vld_s2 && !ctr_s2) begin
			sum_q <= sum_q + SUM_W'(ram_rdata);
		end
		if (vld_s2 && ctr_s2) begin
			centre_q <= ram_rdata;
		end
		// Results: zero for an out-of-volume query or an empty neighbourhood.
		if (state_q == ST_IDLE) begin
			res_value_q <= '0;
			res_cnt_q   <= '0;
		end else if (state_q == ST_DRAIN) begin
			res_value_q <= '0;
			res_cnt_q   <= OUT_CNT_W'(cnt_q);
		end else if (state_q == ST_DIV && div_done) begin
			res_value_q <= (centre_ext > div_quot) ? VAL_W'(centre_ext - div_quot) : '0;
			res_cnt_q   <= OUT_CNT_W'(cnt_q);
		end
	end

	slms3d_ram #(
		.WIDTH (VAL_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (voxel_value),
		.re    (vld_s1),
		.raddr (addr_s1),
		.rdata (ram_rdata)
	);

	// Rounded-up mean: (sum + count - 1) / count.
	slms3d_div #(
		.NW (NUM_W),
		.DW (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign result_valid    = res_valid_q;
	assign result_value    = res_value_q;
	assign neighbour_count = res_cnt_q;

endmodule

[design/slms3d_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module slms3d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/slms3d_div.sv]
// Restoring divider producing one quotient bit per cycle.
// No dependencies; used by the core for the rounded-up neighbour mean.
`timescale 1ns / 1ps

module slms3d_div #(
	parameter int NW = 14,
	parameter int DW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int CW = $clog2(NW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] step_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quot_q;
	logic [DW-1:0] dsr_q;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          qbit;
	logic [DW-1:0] rem_next;

	// The partial remainder stays below the divisor, so it fits in DW bits.
	assign trial    = {rem_q, quot_q[NW-1]};
	assign diff     = trial - {1'b0, dsr_q};
	assign qbit     = ~diff[DW];
	assign rem_next = qbit ? diff[DW-1:0] : trial[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			step_q <= CW'(NW);
		end else if (run_q) begin
			step_q <= step_q - CW'(1);
			if (step_q == CW'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			dsr_q  <= divisor;
		end else if (run_q) begin
			rem_q  <= rem_next;
			quot_q <= {quot_q[NW-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

[design/slms3d_checker.sv]
// Port-level checker for the sparse local mean subtraction core, bound to the top level.
// Depends on slms3d_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sparse_local_mean_subtract_3d_core_assert.svh"

module slms3d_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic cmd,
	input logic result_valid
);

	logic acc_query;
	logic acc_write;

	assign acc_query = start && !busy && (cmd == slms3d_pkg::CMD_QUERY);
	assign acc_write = start && !busy && (cmd == slms3d_pkg::CMD_WRITE);

	// A query either starts work or answers at once.
	`SLMS3D_ASSERT_NEXT(a_query_progress, acc_query, busy || result_valid, "query item dropped")
	// A write item never produces a result and never occupies the block.
	`SLMS3D_ASSERT_NEXT(a_write_silent, acc_write, !busy && !result_valid, "write item misbehaved")
	// Results only appear once the block is free again.
	`SLMS3D_ASSERT_NOW(a_result_idle, result_valid, !busy, "result while busy")
	// Every finished query delivers its result in the cycle the block frees up.
	`SLMS3D_ASSERT_NOW(a_done_result, $fell(busy), result_valid, "query ended without result")

endmodule

bind sparse_local_mean_subtract_3d_core slms3d_checker u_slms3d_checker (.*);

[test/testbench.sv]
// Self-checking testbench for sparse_local_mean_subtract_3d_core.
// Depends on slms3d_pkg and the core RTL. A queue-fed driver sends voxel writes and queries,
// and a clocked monitor compares each result strobe with a local model of the voxel volume.
`timescale 1ns / 1ps

module testbench;

	localparam int HALF_PERIOD   = 6;
	localparam int SETTLE_CYCLES = 60;
	localparam int RUN_LIMIT_NS  = 5_000_000;

	typedef struct {
		logic                           cmd;
		logic [slms3d_pkg::VALUE_W-1:0] value;
		logic [slms3d_pkg::POS_X_W-1:0] x;
		logic [slms3d_pkg::POS_Y_W-1:0] y;
		logic [slms3d_pkg::POS_Z_W-1:0] z;
	} voxel_cmd_t;

	typedef struct {
		logic [slms3d_pkg::VALUE_W-1:0] value;
		logic [slms3d_pkg::COUNT_W-1:0] count;
	} mean_result_t;

	typedef struct {
		int unsigned x;
		int unsigned y;
		int unsigned z;
	} voxel_pos_t;

	typedef voxel_pos_t pos_list_t[$];

	logic                              clk          = 1'b0;
	logic                              arst_n       = 1'b0;
	logic                              start        = 1'b0;
	logic                              cmd          = slms3d_pkg::CMD_WRITE;
	logic [slms3d_pkg::VALUE_W-1:0]    voxel_value  = '0;
	logic [slms3d_pkg::POS_X_W-1:0]    pos_x        = '0;
	logic [slms3d_pkg::POS_Y_W-1:0]    pos_y        = '0;
	logic [slms3d_pkg::POS_Z_W-1:0]    pos_z        = '0;
	logic                              cfg_we       = 1'b0;
	logic [slms3d_pkg::CFG_IDX_W-1:0]  cfg_index    = slms3d_pkg::REG_WIDTH;
	logic [slms3d_pkg::CFG_DATA_W-1:0] cfg_wdata    = '0;
	logic                              busy;
	logic                              result_valid;
	logic [slms3d_pkg::VALUE_W-1:0]    result_value;
	logic [slms3d_pkg::COUNT_W-1:0]    neighbour_count;

	voxel_cmd_t   voxel_cmds[$];
	mean_result_t pending_means[$];
	logic [7:0]   voxel_shadow[int];
	bit           voxel_planned[int];

	// Raw register values as written; the effective sizes are clamped on use.
	int unsigned reg_width  = slms3d_pkg::WIDTH_RST;
	int unsigned reg_height = slms3d_pkg::HEIGHT_RST;
	int unsigned reg_layers = slms3d_pkg::LAYERS_RST;

	int           idle_pct     = 0;
	int           idle_left    = 0;
	int           fail_count   = 0;
	int           items_queued = 0;
	voxel_cmd_t   cur_cmd;
	mean_result_t want;

	sparse_local_mean_subtract_3d_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.voxel_value    (voxel_value),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.result_valid   (result_valid),
		.result_value   (result_value),
		.neighbour_count(neighbour_count)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic int unsigned active_size(input int unsigned r, input int unsigned cap);
		return (r > cap) ? cap : r;
	endfunction

	function automatic int voxel_addr(input voxel_pos_t p);
		return (p.z * slms3d_pkg::MAX_HEIGHT_DEF + p.y) * slms3d_pkg::MAX_WIDTH_DEF + p.x;
	endfunction

	function automatic bit in_volume(input voxel_pos_t p);
		return p.x < active_size(reg_width, slms3d_pkg::MAX_WIDTH_DEF)
			&& p.y < active_size(reg_height, slms3d_pkg::MAX_HEIGHT_DEF)
			&& p.z < active_size(reg_layers, slms3d_pkg::MAX_LAYERS_DEF);
	endfunction

	// Neighbours that a query at c averages. A neighbour below the centre counts only when
	// the coordinate is strictly above the offset, so index 0 is never used.
	function automatic pos_list_t neighbours_of(input voxel_pos_t c);
		pos_list_t   nb;
		int unsigned w;
		int unsigned h;
		int unsigned l;
		int unsigned off;
		w = active_size(reg_width, slms3d_pkg::MAX_WIDTH_DEF);
		h = active_size(reg_height, slms3d_pkg::MAX_HEIGHT_DEF);
		l = active_size(reg_layers, slms3d_pkg::MAX_LAYERS_DEF);
		for (int n = 1; n <= slms3d_pkg::RING_COUNT_DEF; n++) begin
			off = slms3d_pkg::STEP_SPACING_DEF * n;
			if (c.x > off) nb.push_back('{c.x - off, c.y, c.z});
			if (c.x + off < w) nb.push_back('{c.x + off, c.y, c.z});
			if (c.y > off) nb.push_back('{c.x, c.y - off, c.z});
			if (c.y + off < h) nb.push_back('{c.x, c.y + off, c.z});
			if (c.z > off) nb.push_back('{c.x, c.y, c.z - off});
			if (c.z + off < l) nb.push_back('{c.x, c.y, c.z + off});
		end
		return nb;
	endfunction

	function automatic int unsigned shadow_at(input voxel_pos_t p);
		return voxel_shadow.exists(voxel_addr(p)) ? voxel_shadow[voxel_addr(p)] : 0;
	endfunction

	// Applies one accepted item to the local volume and queues the result a query yields.
	function automatic void apply_voxel_cmd(input voxel_cmd_t it);
		voxel_pos_t   c;
		pos_list_t    nb;
		mean_result_t res;
		int unsigned  sum;
		int unsigned  mean_up;
		int unsigned  centre;
		int unsigned  n_nb;
		int unsigned  diff;
		c = '{it.x, it.y, it.z};
		res.value = '0;
		res.count = '0;
		if (it.cmd == slms3d_pkg::CMD_WRITE) begin
			if (in_volume(c)) voxel_shadow[voxel_addr(c)] = it.value;
			return;
		end
		if (in_volume(c)) begin
			nb = neighbours_of(c);
			sum = 0;
			foreach (nb[i]) sum += shadow_at(nb[i]);
			n_nb = nb.size();
			res.count = n_nb[slms3d_pkg::COUNT_W-1:0];
			if (n_nb != 0) begin
				mean_up = (sum + n_nb - 1) / n_nb;
				centre = shadow_at(c);
				diff = (centre > mean_up) ? centre - mean_up : 0;
				res.value = diff[slms3d_pkg::VALUE_W-1:0];
			end
		end
		pending_means.push_back(res);
	endfunction

	// Driver: start stays up until the item is taken, then the next one follows or a gap.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				apply_voxel_cmd(cur_cmd);
				if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
					idle_left = $urandom_range(1, 13);
			end
			if (!(start && busy)) begin
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (voxel_cmds.size() != 0) begin
					cur_cmd = voxel_cmds.pop_front();
					start <= 1'b1;
					cmd <= cur_cmd.cmd;
					voxel_value <= cur_cmd.value;
					pos_x <= cur_cmd.x;
					pos_y <= cur_cmd.y;
					pos_z <= cur_cmd.z;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_means.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual value %0d count %0d",
					$time, result_value, neighbour_count);
				fail_count++;
			end else begin
				want = pending_means.pop_front();
				if (result_value !== want.value) begin
					$display("%0t: result_value mismatch, expected %0d actual %0d",
						$time, want.value, result_value);
					fail_count++;
				end
				if (neighbour_count !== want.count) begin
					$display("%0t: neighbour_count mismatch, expected %0d actual %0d",
						$time, want.count, neighbour_count);
					fail_count++;
				end
			end
		end
	end

	task automatic push_item(input logic c, input int unsigned v, input int unsigned x,
			input int unsigned y, input int unsigned z);
		voxel_cmd_t it;
		it.cmd = c;
		it.value = v[slms3d_pkg::VALUE_W-1:0];
		it.x = x[slms3d_pkg::POS_X_W-1:0];
		it.y = y[slms3d_pkg::POS_Y_W-1:0];
		it.z = z[slms3d_pkg::POS_Z_W-1:0];
		if (c == slms3d_pkg::CMD_WRITE && in_volume('{it.x, it.y, it.z}))
			voxel_planned[voxel_addr('{it.x, it.y, it.z})] = 1'b1;
		voxel_cmds.push_back(it);
		items_queued++;
	endtask

	// A query never reads a voxel that was never written: missing ones are written first.
	task automatic push_query(input int unsigned x, input int unsigned y, input int unsigned z);
		voxel_pos_t c;
		pos_list_t  need;
		c = '{x % slms3d_pkg::MAX_WIDTH_DEF, y % slms3d_pkg::MAX_HEIGHT_DEF,
			z % slms3d_pkg::MAX_LAYERS_DEF};
		if (in_volume(c)) begin
			need = neighbours_of(c);
			need.push_back(c);
			foreach (need[i])
				if (!voxel_planned.exists(voxel_addr(need[i])))
					push_item(slms3d_pkg::CMD_WRITE, $urandom_range(0, 255), need[i].x,
						need[i].y, need[i].z);
		end
		push_item(slms3d_pkg::CMD_QUERY, $urandom_range(0, 255), c.x, c.y, c.z);
	endtask

	// Sampled at the falling edge so the driver's updates for the cycle have settled.
	task automatic wait_idle();
		do @(negedge clk);
		while (voxel_cmds.size() != 0 || start || busy || pending_means.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_volume(input int unsigned w, input int unsigned h, input int unsigned l);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= slms3d_pkg::REG_WIDTH;
		cfg_wdata <= w[slms3d_pkg::CFG_DATA_W-1:0];
		reg_width = w[slms3d_pkg::DIM_XY_W-1:0];
		@(posedge clk);
		cfg_index <= slms3d_pkg::REG_HEIGHT;
		cfg_wdata <= h[slms3d_pkg::CFG_DATA_W-1:0];
		reg_height = h[slms3d_pkg::DIM_XY_W-1:0];
		@(posedge clk);
		cfg_index <= slms3d_pkg::REG_LAYERS;
		cfg_wdata <= l[slms3d_pkg::CFG_DATA_W-1:0];
		reg_layers = l[slms3d_pkg::DIM_Z_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Most queries land on a lattice around one base point so that neighbours get reused.
	task automatic random_phase(input int n_items, input int pct);
		int          goal;
		int unsigned kind;
		int unsigned bx;
		int unsigned by;
		int unsigned bz;
		int unsigned qx;
		int unsigned qy;
		int unsigned qz;
		goal = items_queued + n_items;
		idle_pct = pct;
		bx = $urandom_range(0, 127);
		by = $urandom_range(0, 127);
		bz = $urandom_range(0, 31);
		while (items_queued < goal) begin
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				qx = (bx + slms3d_pkg::STEP_SPACING_DEF * $urandom_range(0, 4))
					% slms3d_pkg::MAX_WIDTH_DEF;
				qy = (by + slms3d_pkg::STEP_SPACING_DEF * $urandom_range(0, 4))
					% slms3d_pkg::MAX_HEIGHT_DEF;
				qz = (bz + slms3d_pkg::STEP_SPACING_DEF * $urandom_range(0, 3))
					% slms3d_pkg::MAX_LAYERS_DEF;
				if ($urandom_range(0, 99) < 40)
					push_item(slms3d_pkg::CMD_WRITE, $urandom_range(128, 255), qx, qy, qz);
				push_query(qx, qy, qz);
			end else if (kind < 85) begin
				push_query($urandom_range(0, 127), $urandom_range(0, 127),
					$urandom_range(0, 31));
			end else begin
				push_item(slms3d_pkg::CMD_WRITE, $urandom_range(0, 255),
					$urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 31));
			end
		end
	endtask

	initial begin
		#(RUN_LIMIT_NS);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: the far corner of the full volume at reset sizes.
		push_item(slms3d_pkg::CMD_WRITE, 255, 127, 127, 31);
		push_query(127, 127, 31);
		wait_idle();

		// A single row of 11 voxels: the lower-bound rule, the upper bound and out-of-volume items.
		set_volume(11, 1, 1);
		push_item(slms3d_pkg::CMD_WRITE, 0, 0, 0, 0);
		push_item(slms3d_pkg::CMD_WRITE, 200, 5, 0, 0);
		push_item(slms3d_pkg::CMD_WRITE, 51, 10, 0, 0);
		push_query(5, 0, 0);
		push_query(10, 0, 0);
		push_query(0, 0, 0);
		push_item(slms3d_pkg::CMD_WRITE, 77, 5, 1, 0);
		push_query(127, 127, 31);
		wait_idle();

		// One voxel in use: a query has no neighbours at all.
		set_volume(1, 1, 1);
		push_query(0, 0, 0);
		wait_idle();

		set_volume(128, 128, 32);
		random_phase(90, 40);
		wait_idle();
		random_phase(90, 40);
		wait_idle();

		// Register values above the maximum clamp to the full volume.
		set_volume(255, 255, 63);
		random_phase(80, 0);
		wait_idle();

		// Empty volume: writes are dropped and every query returns zero.
		set_volume(0, $urandom_range(1, 128), $urandom_range(1, 32));
		random_phase(30, 50);
		wait_idle();

		set_volume($urandom_range(1, 128), $urandom_range(1, 128), $urandom_range(1, 32));
		random_phase(100, 25);
		wait_idle();

		set_volume(1, 128, 32);
		random_phase(60, 60);
		wait_idle();

		set_volume(128, 128, 32);
		random_phase(100, 0);
		wait_idle();

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
